// ----- rtl/tlec_pkg.sv -----
`default_nettype none

package tlec_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int FLAG_W = 7;
  localparam int FL_NUL = 0;
  localparam int FL_CR = 1;
  localparam int FL_LONE_CR = 2;
  localparam int FL_LF = 3;
  localparam int FL_LONE_LF = 4;
  localparam int FL_CRLF = 5;
  localparam int FL_LONG = 6;

  localparam int MASK_W = 9;
  localparam int LEN_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 1'd1;

  localparam logic [MASK_W-1:0] STOP_MASK_RST = 9'd0;
  localparam logic [LEN_W-1:0] LINE_LIMIT_RST = 16'd8191;
  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_blob;
  } in_item_t;

  typedef struct packed {
    logic nul_found;
    logic cr_found;
    logic lone_cr_found;
    logic lf_found;
    logic lone_lf_found;
    logic crlf_found;
    logic long_line_found;
    logic scan_cut_short;
    logic maybe_binary;
  } out_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flag_bits;
    logic [LEN_W-1:0]  line_length;
    logic              previous_was_cr;
    logic              scan_stopped;
  } scan_state_t;

endpackage

`default_nettype wire

// ----- rtl/text_line_ending_classifier.sv -----
// Line-ending classifier: bytes of a blob enter on the in_ channel, one item
// per byte, the final byte marked by last_byte, or a whole empty blob as one
// item with empty_blob set. One result item leaves on the out_ channel per
// blob, carrying the NUL, CR, lone CR, LF, lone LF, CRLF, long-line,
// cut-short and maybe-binary flags.
// An item is taken when valid is high and stall is low on its channel.
// A blob's result is registered: its last item sits in the input register
// while the scan logic works on it, and the output register loads as the
// item advances. The block takes one byte per clock while in_stall is low,
// set by the single scan update that runs between the input register and
// the state registers.
// While the output register holds a result the receiver stalls, the next
// byte that carries no result still moves on; an item that ends a blob waits
// in the input register and in_stall rises until the output register frees.
// Configuration goes in via cfg_we, cfg_index and cfg_wdata; the user must
// write it only while idle (the block does not check). Synchronous reset
// clears all scan state and both valid regs; stop_mask 0, line_limit 8191.
`default_nettype none

module text_line_ending_classifier (
  input  var logic                                clk,
  input  var logic                                rst_n,
  input  var logic                                in_valid,
  output logic                                    in_stall,
  input  var tlec_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  var logic                                out_stall,
  output tlec_pkg::out_item_t                     out_data,
  input  var logic                                cfg_we,
  input  var logic [tlec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  var logic [tlec_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [tlec_pkg::MASK_W-1:0] stop_mask_r;
  logic [tlec_pkg::LEN_W-1:0]  line_limit_r;
  logic                        s1_valid_r;
  tlec_pkg::in_item_t          s1_item_r;
  tlec_pkg::scan_state_t       state_r;
  tlec_pkg::scan_state_t       state_nxt;
  logic                        out_valid_r;
  tlec_pkg::out_item_t         out_data_r;
  tlec_pkg::out_item_t         step_result;
  logic                        step_has_result;
  logic                        out_free;
  logic                        s1_adv;
  logic                        in_take;

  tlec_step u_step (
    .state_cur  (state_r),
    .item       (s1_item_r),
    .stop_mask  (stop_mask_r),
    .line_limit (line_limit_r),
    .state_nxt  (state_nxt),
    .result     (step_result),
    .has_result (step_has_result)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!step_has_result || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mask_r  <= tlec_pkg::STOP_MASK_RST;
      line_limit_r <= tlec_pkg::LINE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlec_pkg::CFG_STOP_MASK: begin
          stop_mask_r <= cfg_wdata[tlec_pkg::MASK_W-1:0];
        end
        tlec_pkg::CFG_LINE_LIMIT: begin
          line_limit_r <= cfg_wdata[tlec_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && step_has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step_has_result) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.empty_blob |=> out_valid_r && (out_data_r == '0))
    else $error("empty blob did not give an all-clear result");

  a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && step_has_result |=> state_r == '0)
    else $error("scan state not cleared after a blob ended");

  a_binary_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.maybe_binary == (out_data_r.nul_found
      || out_data_r.long_line_found || out_data_r.scan_cut_short))
    else $error("maybe_binary disagrees with its source flags");

  a_lf_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.lone_lf_found || out_data_r.crlf_found)
      |-> out_data_r.lf_found)
    else $error("line feed kind reported without a line feed");

endmodule

`default_nettype wire

// ----- rtl/tlec_step.sv -----
`default_nettype none

module tlec_step (
  input  var tlec_pkg::scan_state_t             state_cur,
  input  var tlec_pkg::in_item_t                item,
  input  var logic [tlec_pkg::MASK_W-1:0]       stop_mask,
  input  var logic [tlec_pkg::LEN_W-1:0]        line_limit,
  output tlec_pkg::scan_state_t                 state_nxt,
  output tlec_pkg::out_item_t                   result,
  output logic                                  has_result
);

  logic [tlec_pkg::FLAG_W-1:0] flags;
  logic [tlec_pkg::FLAG_W-1:0] flags_end;
  logic [tlec_pkg::LEN_W-1:0]  len;
  logic                        pend_cr;
  logic                        stopped;
  logic                        stopped_end;
  logic                        long_end;
  logic                        had_cr;
  logic                        is_lf;
  logic                        is_cr;

  always_comb begin
    had_cr = state_cur.previous_was_cr;
    is_lf = (item.data_byte == tlec_pkg::CH_LF);
    is_cr = (item.data_byte == tlec_pkg::CH_CR);

    flags = state_cur.flag_bits;
    if (had_cr && !is_lf) begin
      flags[tlec_pkg::FL_LONE_CR] = 1'b1;
    end
    stopped = state_cur.scan_stopped
              || ((flags & stop_mask[tlec_pkg::FLAG_W-1:0]) != '0);
    len = state_cur.line_length;
    pend_cr = 1'b0;

    if (!stopped) begin
      if (len != tlec_pkg::LEN_MAX) begin
        len = len + 1'b1;
      end
      if (item.data_byte == 8'd0) begin
        flags[tlec_pkg::FL_NUL] = 1'b1;
      end else if (is_lf) begin
        flags[tlec_pkg::FL_LF] = 1'b1;
        if (had_cr) begin
          flags[tlec_pkg::FL_CR] = 1'b1;
          flags[tlec_pkg::FL_CRLF] = 1'b1;
        end else begin
          flags[tlec_pkg::FL_LONE_LF] = 1'b1;
        end
        if (len > line_limit) begin
          flags[tlec_pkg::FL_LONG] = 1'b1;
        end
        len = '0;
      end else if (is_cr) begin
        flags[tlec_pkg::FL_CR] = 1'b1;
        pend_cr = 1'b1;
      end
    end

    // End of blob: a trailing CR is lone, and the unterminated tail is checked.
    flags_end = flags;
    if (pend_cr) begin
      flags_end[tlec_pkg::FL_LONE_CR] = 1'b1;
    end
    stopped_end = stopped || ((flags_end & stop_mask[tlec_pkg::FLAG_W-1:0]) != '0);
    long_end = flags_end[tlec_pkg::FL_LONG] || (len > line_limit);

    has_result = item.empty_blob || item.last_byte;

    if (item.empty_blob) begin
      result = '0;
    end else begin
      result.nul_found       = flags_end[tlec_pkg::FL_NUL];
      result.cr_found        = flags_end[tlec_pkg::FL_CR];
      result.lone_cr_found   = flags_end[tlec_pkg::FL_LONE_CR];
      result.lf_found        = flags_end[tlec_pkg::FL_LF];
      result.lone_lf_found   = flags_end[tlec_pkg::FL_LONE_LF];
      result.crlf_found      = flags_end[tlec_pkg::FL_CRLF];
      result.long_line_found = long_end;
      result.scan_cut_short  = stopped_end;
      result.maybe_binary    = flags_end[tlec_pkg::FL_NUL] || long_end || stopped_end;
    end

    if (has_result) begin
      state_nxt = '0;
    end else begin
      state_nxt.flag_bits       = flags;
      state_nxt.line_length     = len;
      state_nxt.previous_was_cr = pend_cr;
      state_nxt.scan_stopped    = stopped;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_text_line_ending_classifier.sv -----
`timescale 1ns / 100ps

module tb_text_line_ending_classifier;
  import tlec_pkg::*;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_A = 8'h61;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;

  class line_flag_board;
    logic [MASK_W-1:0] stop_mask;
    logic [LEN_W-1:0] line_limit;
    logic [FLAG_W-1:0] flags;
    logic [LEN_W-1:0] line_len;
    bit prev_cr;
    bit stopped;
    out_item_t expected_flags[$];
    int mismatch_count;

    function new();
      stop_mask = STOP_MASK_RST;
      line_limit = LINE_LIMIT_RST;
      mismatch_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      flags = '0;
      line_len = '0;
      prev_cr = 1'b0;
      stopped = 1'b0;
    endfunction

    function void note_byte(in_item_t it);
      bit had_cr;
      out_item_t res;
      if (it.empty_blob) begin
        clear_scan();
        expected_flags.push_back('0);
        return;
      end
      had_cr = prev_cr;
      if (had_cr && it.data_byte != CH_LF) flags[FL_LONE_CR] = 1'b1;
      prev_cr = 1'b0;
      if ((flags & stop_mask[FLAG_W-1:0]) != '0) stopped = 1'b1;
      if (!stopped) begin
        if (line_len != LEN_MAX) line_len = line_len + 1'b1;
        if (it.data_byte == BYTE_NUL) begin
          flags[FL_NUL] = 1'b1;
        end else if (it.data_byte == CH_LF) begin
          flags[FL_LF] = 1'b1;
          if (had_cr) begin
            flags[FL_CR] = 1'b1;
            flags[FL_CRLF] = 1'b1;
          end else begin
            flags[FL_LONE_LF] = 1'b1;
          end
          if (line_len > line_limit) flags[FL_LONG] = 1'b1;
          line_len = '0;
        end else if (it.data_byte == CH_CR) begin
          flags[FL_CR] = 1'b1;
          prev_cr = 1'b1;
        end
      end
      if (!it.last_byte) return;
      if (prev_cr) flags[FL_LONE_CR] = 1'b1;
      if ((flags & stop_mask[FLAG_W-1:0]) != '0) stopped = 1'b1;
      if (line_len > line_limit) flags[FL_LONG] = 1'b1;
      res.nul_found = flags[FL_NUL];
      res.cr_found = flags[FL_CR];
      res.lone_cr_found = flags[FL_LONE_CR];
      res.lf_found = flags[FL_LF];
      res.lone_lf_found = flags[FL_LONE_LF];
      res.crlf_found = flags[FL_CRLF];
      res.long_line_found = flags[FL_LONG];
      res.scan_cut_short = stopped;
      res.maybe_binary = flags[FL_NUL] | flags[FL_LONG] | stopped;
      expected_flags.push_back(res);
      clear_scan();
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task compare_flag(string name, logic got, logic want);
      if (got !== want)
        report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    endtask

    task check_flags(out_item_t got);
      out_item_t want;
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b", got));
        return;
      end
      want = expected_flags.pop_front();
      compare_flag("nul_found", got.nul_found, want.nul_found);
      compare_flag("cr_found", got.cr_found, want.cr_found);
      compare_flag("lone_cr_found", got.lone_cr_found, want.lone_cr_found);
      compare_flag("lf_found", got.lf_found, want.lf_found);
      compare_flag("lone_lf_found", got.lone_lf_found, want.lone_lf_found);
      compare_flag("crlf_found", got.crlf_found, want.crlf_found);
      compare_flag("long_line_found", got.long_line_found, want.long_line_found);
      compare_flag("scan_cut_short", got.scan_cut_short, want.scan_cut_short);
      compare_flag("maybe_binary", got.maybe_binary, want.maybe_binary);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STOP_MASK;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  line_flag_board sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_seen = 0;
  int hold_left = 0;

  text_line_ending_classifier dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_flags(out_data);
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(it);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    it.empty_blob = 1'b0;
    push_item(it);
  endtask

  task automatic push_empty();
    in_item_t it;
    it.data_byte = 8'($urandom_range(255));
    it.last_byte = 1'($urandom_range(1));
    it.empty_blob = 1'b1;
    push_item(it);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return CH_CR;
    if (r < 32) return CH_LF;
    if (r < 37) return BYTE_NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STOP_MASK;
    cfg_wdata <= CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_index <= CFG_LINE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.stop_mask = mask;
    sb.line_limit = limit;
  endtask

  initial begin
    #(20_000_000);
    $display("text_line_ending_classifier regression: fail");
    $finish;
  end

  initial begin
    int sent;
    int len;
    int r;
    logic [MASK_W-1:0] mask;
    logic [LEN_W-1:0] limit;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 66;
    push_empty();
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b1);
    push_byte(CH_LF, 1'b1);
    push_byte(BYTE_A, 1'b0);
    push_byte(CH_CR, 1'b1);
    push_byte(CH_CR, 1'b0);
    push_byte(BYTE_NUL, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(CH_CR, 1'b0);
    push_empty();
    push_byte(8'h7A, 1'b1);
    drain();
    write_config('1, 16'd1);
    push_byte(BYTE_NUL, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b1);
    push_byte(8'h78, 1'b0);
    push_byte(8'h79, 1'b1);
    drain();
    write_config(MASK_W'(1) << FL_CR, 16'd65534);
    push_byte(CH_CR, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(CH_LF, 1'b1);
    drain();
    write_config(9'h180, 16'd0);
    push_byte(CH_LF, 1'b0);
    push_byte(BYTE_NUL, 1'b1);
    drain();
    write_config('0, LEN_MAX);
    push_byte(BYTE_A, 1'b0);
    push_byte(CH_LF, 1'b0);
    drain();
    write_config(MASK_W'(1) << FL_LF, LEN_MAX);
    push_byte(8'h63, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 66 : 0;
      recv_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 10 : 0;
      r = $urandom_range(99);
      if (r < 40) mask = '0;
      else if (r < 70) mask = MASK_W'(1) << $urandom_range(FLAG_W - 1);
      else mask = MASK_W'($urandom());
      r = $urandom_range(99);
      if (r < 70) limit = LEN_W'($urandom_range(1, 24));
      else if (r < 85) limit = LEN_W'($urandom());
      else limit = (r < 92) ? 16'd1 : 16'd65534;
      write_config(mask, limit);
      if (ph == 4) hold_request <= hold_request + 1;
      sent = 0;
      while (sent < 235) begin
        r = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
        if (r < 5) begin
          push_empty();
          sent += 1;
        end else if (r < 9) begin
          for (int i = 0; i < len; i++) push_byte(pick_byte(), 1'b0);
          push_empty();
          sent += len + 1;
        end else begin
          for (int i = 0; i < len; i++) push_byte(pick_byte(), i == len - 1);
          sent += len;
        end
      end
      drain();
    end

    if (sb.mismatch_count == 0) begin
      $display("text_line_ending_classifier regression: pass");
    end else begin
      $display("text_line_ending_classifier regression: fail");
    end
    $finish;
  end

endmodule

// ----- text_line_ending_classifier.f -----
rtl/tlec_pkg.sv
rtl/tlec_step.sv
rtl/text_line_ending_classifier.sv
tb/tb_text_line_ending_classifier.sv
